// File: src/lpd_pkg.sv
// Shared types, constants and pattern functions of the LED pattern driver.
package lpd_pkg;

  localparam int CHANNELS  = 6;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OUT_W     = 6;
  localparam int OUT_CH    = (CHANNELS < OUT_W) ? CHANNELS : OUT_W;
  localparam int TIME_W    = 32;
  localparam int PHASE_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'd1;

  localparam logic [2:0] PAT_OFF    = 3'd0;
  localparam logic [2:0] PAT_SOLID  = 3'd1;
  localparam logic [2:0] PAT_FAST   = 3'd2;
  localparam logic [2:0] PAT_SLOW   = 3'd3;
  localparam logic [2:0] PAT_DOUBLE = 3'd4;
  localparam logic [2:0] PAT_TRIPLE = 3'd5;

  localparam logic [PHASE_W-1:0] FAST_PERIOD  = 11'd200;
  localparam logic [PHASE_W-1:0] FAST_ON      = 11'd100;
  localparam logic [PHASE_W-1:0] SLOW_PERIOD  = 11'd1000;
  localparam logic [PHASE_W-1:0] SLOW_ON      = 11'd200;
  localparam logic [PHASE_W-1:0] PULSE_PERIOD = 11'd2000;
  localparam logic [PHASE_W-1:0] PULSE_LEN    = 11'd80;
  localparam logic [PHASE_W-1:0] PULSE2_START = 11'd200;
  localparam logic [PHASE_W-1:0] PULSE2_END   = 11'd280;
  localparam logic [PHASE_W-1:0] PULSE3_START = 11'd400;
  localparam logic [PHASE_W-1:0] PULSE3_END   = 11'd480;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FOLD,
    S_REDUCE,
    S_DECIDE,
    S_DONE
  } state_t;

  // Period of the pattern; patterns without a period use any nonzero value.
  function automatic logic [PHASE_W-1:0] pattern_period(input logic [2:0] pat);
    logic [PHASE_W-1:0] p;
    unique case (pat)
      PAT_FAST:               p = FAST_PERIOD;
      PAT_SLOW:               p = SLOW_PERIOD;
      PAT_DOUBLE, PAT_TRIPLE: p = PULSE_PERIOD;
      default:                p = FAST_PERIOD;
    endcase
    return p;
  endfunction

  function automatic logic pattern_lit(input logic [2:0] pat,
                                       input logic [PHASE_W-1:0] ph);
    logic lit;
    unique case (pat)
      PAT_SOLID:  lit = 1'b1;
      PAT_FAST:   lit = (ph < FAST_ON);
      PAT_SLOW:   lit = (ph < SLOW_ON);
      PAT_DOUBLE: lit = (ph < PULSE_LEN) || ((ph >= PULSE2_START) && (ph < PULSE2_END));
      PAT_TRIPLE: lit = (ph < PULSE_LEN) || ((ph >= PULSE2_START) && (ph < PULSE2_END)) ||
                        ((ph >= PULSE3_START) && (ph < PULSE3_END));
      default:    lit = 1'b0;
    endcase
    return lit;
  endfunction

endpackage

// File: src/led_pattern_driver.sv
// Top level of the LED pattern driver: channel state, sequencer and shared remainder unit.
//
//   channel | ports                                            | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid/in_ready, operation, channel, pattern,  | input
//           | now_ms                                           |
//   out     | out_valid/out_ready, on_mask, drive_mask,        | output
//           | written_mask                                     |
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data         | input
//
// Each updated channel runs through these steps: load the elapsed time, fold it below
// 2048 while keeping it modulo the period, compare and subtract to bring it below the
// period, then decide the lit value. A tick updates every channel in turn, a set only
// its own channel, and a set with an out-of-range channel goes straight to its result.
// Reset (rst_n low, synchronous) clears patterns and output-valid bits, resets the config
// registers and the handshakes. The result sits in an output register, so the next item
// is taken while it waits; a stalled out channel holds the sequencer in its final state
// only once a second result is ready.
module led_pattern_driver import lpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [2:0]           in_channel,
  input  logic [2:0]           in_pattern,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     out_on_mask,
  output logic [OUT_W-1:0]     out_drive_mask,
  output logic [OUT_W-1:0]     out_written_mask,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OUT_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  // Per-channel state.
  logic [2:0]        pattern_r [CHANNELS];
  logic [TIME_W-1:0] start_r   [CHANNELS];
  logic [CHANNELS-1:0] lit_r;
  logic [CHANNELS-1:0] valid_r;

  // Item and sequencer registers.
  logic                 op_r;
  logic [TIME_W-1:0]    now_r;
  logic [CH_IDX_W-1:0]  cur_r;
  logic [CHANNELS-1:0]  written_r;
  logic [TIME_W-1:0]    elapsed_r;
  logic [PHASE_W-1:0]   period_r;

  logic [OUT_W-1:0] active_low_r;
  logic [OUT_W-1:0] enable_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] on_r, drive_r, wr_r;

  // Control strobes from the sequencer.
  logic in_xfer, out_load, in_range, last_ch, want;
  logic [TIME_W-1:0]  fold_v;
  logic [PHASE_W-1:0] ph;
  logic folded, below;
  logic [OUT_W-1:0] on_nxt, drive_nxt, wr_nxt;

  assign in_range = (32'(in_channel) < CHANNELS);
  assign last_ch  = (op_r == OP_SET) || (cur_r == CH_IDX_W'(CHANNELS - 1));
  assign ph       = elapsed_r[PHASE_W-1:0];
  assign want     = pattern_lit(pattern_r[cur_r], ph);
  assign folded   = (fold_v[TIME_W-1:PHASE_W] == '0);
  assign below    = (ph < period_r);

  // Fold step: 2048 = 2000 + 48 and every period divides 2000, so replacing
  // hi * 2048 + lo by hi * 48 + lo keeps the value modulo each period.
  always_comb begin
    fold_v = TIME_W'({elapsed_r[TIME_W-1:PHASE_W], 5'b0}) +
             TIME_W'({elapsed_r[TIME_W-1:PHASE_W], 4'b0}) +
             TIME_W'(ph);
  end

  // Output strobes.
  always_comb begin
    in_ready = (state_r == S_IDLE);
    in_xfer  = in_valid && in_ready;
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_operation == OP_SET && !in_range) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: state_nxt = S_FOLD;
      S_FOLD: begin
        if (folded) begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (below) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: state_nxt = last_ch ? S_DONE : S_LOAD;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result word from the channel state and the config registers.
  always_comb begin
    on_nxt    = '0;
    drive_nxt = '0;
    wr_nxt    = '0;
    for (int c = 0; c < OUT_CH; c++) begin
      on_nxt[c]    = lit_r[c];
      drive_nxt[c] = enable_r[c] && (lit_r[c] ^ active_low_r[c]);
      wr_nxt[c]    = written_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      lit_r        <= '0;
      active_low_r <= '0;
      enable_r     <= '1;
      out_valid_r  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        pattern_r[c] <= PAT_OFF;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ACTIVE_LOW: active_low_r <= cfg_data;
          REG_ENABLE:     enable_r     <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r      <= in_operation;
            now_r     <= in_now_ms;
            written_r <= '0;
            if (in_operation == OP_TICK) begin
              cur_r <= '0;
            end else if (in_range) begin
              cur_r <= CH_IDX_W'(in_channel);
              // A new pattern restarts the cycle: drop the output-valid bit.
              if (pattern_r[CH_IDX_W'(in_channel)] != in_pattern) begin
                pattern_r[CH_IDX_W'(in_channel)] <= in_pattern;
                valid_r[CH_IDX_W'(in_channel)]   <= 1'b0;
              end
            end
          end
        end
        S_LOAD: begin
          if (valid_r[cur_r]) begin
            elapsed_r <= now_r - start_r[cur_r];
          end else begin
            elapsed_r      <= '0;
            start_r[cur_r] <= now_r;
          end
          period_r <= pattern_period(pattern_r[cur_r]);
        end
        S_FOLD: begin
          elapsed_r <= fold_v;
        end
        S_REDUCE: begin
          // Subtract the period until the phase lies below it.
          if (!below) begin
            elapsed_r <= elapsed_r - TIME_W'(period_r);
          end
        end
        S_DECIDE: begin
          // Rewrite the output when invalid or when the lit value changes.
          if (!valid_r[cur_r] || (want != lit_r[cur_r])) begin
            lit_r[cur_r]     <= want;
            valid_r[cur_r]   <= 1'b1;
            written_r[cur_r] <= 1'b1;
          end
          if (!last_ch) begin
            cur_r <= cur_r + 1'b1;
          end
        end
        S_DONE: ;
        default: ;
      endcase

      // Hold the result until its transfer; load a new one when the register frees.
      if (out_load) begin
        out_valid_r <= 1'b1;
        on_r        <= on_nxt;
        drive_r     <= drive_nxt;
        wr_r        <= wr_nxt;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_on_mask      = on_r;
  assign out_drive_mask   = drive_r;
  assign out_written_mask = wr_r;

endmodule

// File: tb/tb_led_pattern_driver.sv
// Self-checking testbench of the LED pattern driver: queued stimulus, predictor, result checks.
`timescale 1ns / 1ps

module tb_led_pattern_driver;
  import lpd_pkg::*;

  // One input transfer as queued for the driver, with the idle cycles that precede it.
  typedef struct {
    logic              op;
    logic [2:0]        chan;
    logic [2:0]        pat;
    logic [TIME_W-1:0] t_ms;
    int unsigned       gap;
  } lamp_cmd_t;

  // One result transfer as the block should present it.
  typedef struct packed {
    logic [OUT_W-1:0] lit;
    logic [OUT_W-1:0] drive;
    logic [OUT_W-1:0] written;
  } lamp_status_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = OP_TICK;
  logic [2:0]           in_channel = '0;
  logic [2:0]           in_pattern = '0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     out_on_mask;
  logic [OUT_W-1:0]     out_drive_mask;
  logic [OUT_W-1:0]     out_written_mask;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ACTIVE_LOW;
  logic [OUT_W-1:0]     cfg_data = '0;

  // Predictor state: per-channel pattern, cycle start, lit value and output-valid flag,
  // plus its own copy of the two registers.
  logic [2:0]        lamp_pat   [CHANNELS];
  logic [TIME_W-1:0] lamp_start [CHANNELS];
  logic              lamp_on    [CHANNELS];
  logic              lamp_valid [CHANNELS];
  logic [OUT_W-1:0]  low_cfg;
  logic [OUT_W-1:0]  en_cfg;

  lamp_cmd_t    cmd_q[$];     // transfers waiting for the driver
  lamp_cmd_t    cmd_on_bus;   // transfer currently offered on the input channel
  lamp_status_t status_q[$];  // expected results, oldest first

  logic [TIME_W-1:0] clock_ms;
  int unsigned idle_run;
  int unsigned rx_wait;
  int unsigned calm_left;
  int unsigned hold_left;
  int unsigned hold_xfers;
  int unsigned ticks_sent;
  int unsigned sets_sent;
  int unsigned absent_sets;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned mismatches;

  led_pattern_driver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_channel       (in_channel),
    .in_pattern       (in_pattern),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_on_mask      (out_on_mask),
    .out_drive_mask   (out_drive_mask),
    .out_written_mask (out_written_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Print one failure line and count it.
  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Lit value of a pattern after the given wrapped elapsed time; codes 6 and 7 read as off.
  function automatic logic lamp_lit(logic [2:0] pat, logic [TIME_W-1:0] elapsed);
    logic [TIME_W-1:0] ph;
    ph = '0;
    case (pat)
      PAT_SOLID: return 1'b1;
      PAT_FAST:  return (elapsed % 32'd200) < 32'd100;
      PAT_SLOW:  return (elapsed % 32'd1000) < 32'd200;
      PAT_DOUBLE: begin
        ph = elapsed % 32'd2000;
        return (ph < 32'd80) || (ph >= 32'd200 && ph < 32'd280);
      end
      PAT_TRIPLE: begin
        ph = elapsed % 32'd2000;
        return (ph < 32'd80) || (ph >= 32'd200 && ph < 32'd280) ||
               (ph >= 32'd400 && ph < 32'd480);
      end
      default: return 1'b0;
    endcase
  endfunction

  // Refresh one channel at time t_ms; returns 1 when its output gets rewritten.
  function automatic logic refresh_lamp(int c, logic [TIME_W-1:0] t_ms);
    logic want;
    if (!lamp_valid[c])
      lamp_start[c] = t_ms;
    want = lamp_lit(lamp_pat[c], t_ms - lamp_start[c]);
    if (!lamp_valid[c] || want != lamp_on[c]) begin
      lamp_on[c]    = want;
      lamp_valid[c] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted transfer to the predictor and return the status it must produce.
  function automatic lamp_status_t step_lamps(lamp_cmd_t cmd);
    lamp_status_t r;
    int c;
    r = '0;
    if (cmd.op == OP_TICK) begin
      for (c = 0; c < CHANNELS; c++)
        if (refresh_lamp(c, cmd.t_ms) && c < OUT_W)
          r.written[c] = 1'b1;
    end else if (cmd.chan < CHANNELS) begin
      // A new pattern restarts the cycle and invalidates the output first.
      if (lamp_pat[cmd.chan] != cmd.pat) begin
        lamp_pat[cmd.chan]   = cmd.pat;
        lamp_start[cmd.chan] = cmd.t_ms;
        lamp_valid[cmd.chan] = 1'b0;
      end
      if (refresh_lamp(cmd.chan, cmd.t_ms) && cmd.chan < OUT_W)
        r.written[cmd.chan] = 1'b1;
    end
    for (c = 0; c < OUT_CH; c++) begin
      r.lit[c] = lamp_on[c];
      // Disabled channels keep their state but drive a low pin.
      if (en_cfg[c])
        r.drive[c] = lamp_on[c] ^ low_cfg[c];
    end
    return r;
  endfunction

  // Input driver: offer queued transfers, inserting each one's idle gap first.
  // The predictor advances exactly when a transfer is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_run = 0;
    end else begin
      if (in_valid && in_ready) begin
        status_q.push_back(step_lamps(cmd_on_bus));
        if (cmd_on_bus.op == OP_TICK)
          ticks_sent++;
        else begin
          sets_sent++;
          if (cmd_on_bus.chan >= CHANNELS)
            absent_sets++;
        end
      end
      // Hold the payload while an offer is pending; otherwise load the next one.
      if (!in_valid || in_ready) begin
        if (cmd_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_run < cmd_q[0].gap) begin
          idle_run++;
          in_valid <= 1'b0;
        end else begin
          cmd_on_bus = cmd_q.pop_front();
          idle_run   = 0;
          in_valid     <= 1'b1;
          in_operation <= cmd_on_bus.op;
          in_channel   <= cmd_on_bus.chan;
          in_pattern   <= cmd_on_bus.pat;
          in_now_ms    <= cmd_on_bus.t_ms;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation, then draw a stall.
  // Now and then run a calm stretch with no random stalls.
  always @(posedge clk) begin
    lamp_status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   = 0;
      calm_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_checked));
        end else begin
          want = status_q.pop_front();
          if (out_on_mask !== want.lit)
            report_error($sformatf("result %0d on_mask %b, want %b",
                                   results_checked, out_on_mask, want.lit));
          if (out_drive_mask !== want.drive)
            report_error($sformatf("result %0d drive_mask %b, want %b",
                                   results_checked, out_drive_mask, want.drive));
          if (out_written_mask !== want.written)
            report_error($sformatf("result %0d written_mask %b, want %b",
                                   results_checked, out_written_mask, want.written));
        end
        results_checked++;
        if (calm_left != 0) begin
          calm_left--;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 9);
          if ($urandom_range(0, 19) == 0)
            calm_left = 40;
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Back-pressure: after the 201st and 601st result transfer, refuse results for a long
  // stretch so the output register fills and the block stalls its input channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_xfers <= 0;
    end else begin
      if (out_valid && out_ready)
        hold_xfers <= hold_xfers + 1;
      if (out_valid && out_ready && (hold_xfers == 200 || hold_xfers == 600))
        hold_left <= 2500;
      else if (hold_left != 0)
        hold_left <= hold_left - 1;
    end
  end

  // Write one register through the cfg channel and mirror it in the predictor.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OUT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ACTIVE_LOW)
      low_cfg = val;
    else
      en_cfg = val;
    reg_writes++;
  endtask

  // Queue one transfer with a random leading gap.
  task automatic queue_cmd(logic op, logic [2:0] chan, logic [2:0] pat, logic [TIME_W-1:0] t_ms);
    lamp_cmd_t cmd;
    cmd.op   = op;
    cmd.chan = chan;
    cmd.pat  = pat;
    cmd.t_ms = t_ms;
    cmd.gap  = $urandom_range(0, 9);
    cmd_q.push_back(cmd);
  endtask

  // Mostly ticks on an advancing clock with pattern changes in between; a few stray
  // timestamps, big jumps and sets to absent channels as noise. The first quarter
  // of each batch goes back to back.
  task automatic queue_random(int n);
    lamp_cmd_t cmd;
    int k;
    int roll;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)
        clock_ms += $urandom_range(0, 60);
      else if (roll < 90)
        clock_ms += $urandom_range(60, 600);
      else if (roll < 98)
        clock_ms += $urandom_range(600, 3000);
      else
        clock_ms += $urandom();
      cmd.t_ms = ($urandom_range(0, 49) == 0) ? $urandom() : clock_ms;
      cmd.op   = ($urandom_range(0, 9) < 7) ? OP_TICK : OP_SET;
      cmd.chan = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      cmd.pat  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      cmd.gap  = (k < n / 4) ? 0 : $urandom_range(0, 9);
      cmd_q.push_back(cmd);
    end
  endtask

  // Block until every queued transfer went in and every expected result came out,
  // then let the sequencer settle before touching registers.
  task automatic wait_idle();
    do @(negedge clk); while (cmd_q.size() != 0 || in_valid || status_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [OUT_W-1:0] low_set [5];
    logic [OUT_W-1:0] en_set  [5];
    int p;

    // Mirror the reset state of the block.
    low_cfg = '0;
    en_cfg  = '1;
    for (p = 0; p < CHANNELS; p++) begin
      lamp_pat[p]   = PAT_OFF;
      lamp_start[p] = '0;
      lamp_on[p]    = 1'b0;
      lamp_valid[p] = 1'b0;
    end

    // Register settings of the later phases, extremes included.
    low_set = '{6'h3F, 6'h00, 6'h2A, 6'($urandom()), 6'h00};
    en_set  = '{6'h3F, 6'h00, 6'h15, 6'($urandom()), 6'h3F};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset register values.
    // First tick: every output is invalid, so all six get written at time zero.
    queue_cmd(OP_TICK, 3'd0, PAT_OFF, 32'd0);
    // One of each pattern on its own channel.
    queue_cmd(OP_SET, 3'd0, PAT_SOLID,  32'd5);
    queue_cmd(OP_SET, 3'd1, PAT_FAST,   32'd100);
    queue_cmd(OP_SET, 3'd2, PAT_SLOW,   32'd200);
    queue_cmd(OP_SET, 3'd3, PAT_DOUBLE, 32'd300);
    queue_cmd(OP_SET, 3'd4, PAT_TRIPLE, 32'd400);
    // Unused pattern codes are stored and stay dark.
    queue_cmd(OP_SET, 3'd5, 3'd6, 32'd500);
    queue_cmd(OP_SET, 3'd5, 3'd7, 32'd510);
    // Sets to channels that do not exist change nothing.
    queue_cmd(OP_SET, 3'd6, PAT_SOLID,  32'd520);
    queue_cmd(OP_SET, 3'd7, PAT_TRIPLE, 32'd530);
    // Same pattern again: no restart, still inside the lit half of the fast blink.
    queue_cmd(OP_SET, 3'd1, PAT_FAST, 32'd199);
    // Ticks with junk in the ignored fields, across pulse and blink edges.
    queue_cmd(OP_TICK, 3'd7, 3'd7, 32'd200);
    queue_cmd(OP_TICK, 3'd5, 3'd3, 32'd480);
    queue_cmd(OP_TICK, 3'd2, 3'd6, 32'd679);
    queue_cmd(OP_TICK, 3'd0, 3'd0, 32'd680);
    // Restart a fast blink right at the top of the time range and tick across the wrap.
    queue_cmd(OP_SET, 3'd0, PAT_OFF,  32'hFFFF_FFF0);
    queue_cmd(OP_SET, 3'd0, PAT_FAST, 32'hFFFF_FFFF);
    queue_cmd(OP_TICK, 3'd4, 3'd5, 32'h0000_0062);
    queue_cmd(OP_TICK, 3'd1, 3'd2, 32'h0000_0063);
    queue_cmd(OP_TICK, 3'd7, 3'd1, 32'hFFFF_FFFF);
    queue_cmd(OP_TICK, 3'd0, 3'd0, 32'd0);

    clock_ms = 32'd1000;
    queue_random(130);
    wait_idle();

    // Further phases: write both registers while idle, then run a random batch.
    for (p = 0; p < 5; p++) begin
      write_reg(REG_ACTIVE_LOW, low_set[p]);
      write_reg(REG_ENABLE, en_set[p]);
      // Start every other batch just below the wrap point of the millisecond counter.
      clock_ms = (p % 2 == 0) ? 32'hFFFF_F800 : $urandom();
      queue_random(150);
      wait_idle();
    end

    // Drain: give anything unexpected a chance to show up.
    repeat (300) @(posedge clk);
    if (status_q.size() != 0)
      report_error($sformatf("%0d expected results never arrived", status_q.size()));

    $display("Covered %0d ticks and %0d pattern sets (%0d to absent channels), %0d register writes",
             ticks_sent, sets_sent, absent_sets, reg_writes);
    $display("Compared %0d results field by field, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Timeout: stimulus or results stopped moving");
    $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
src/lpd_pkg.sv
src/led_pattern_driver.sv
tb/tb_led_pattern_driver.sv
